// ----- design/psss_pkg.sv -----
// shared types and constants for the packet substring search core
package psss_pkg;

	localparam int BYTE_W     = 8;
	localparam int START_W    = 7;
	localparam int COUNT_W    = 16;
	localparam int CFG_DATA_W = 64;
	localparam int REG_IDX_W  = 2;
	localparam int LEN_CFG_W  = 5;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_FIRST  = 2'd0,
		REG_PATTERN_LAST   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} reg_idx_t;

	// one classified byte handed from the front part to the back part
	typedef struct packed {
		logic               hit;
		logic [START_W-1:0] start;
		logic               last;
		logic               over;
	} item_t;

endpackage

// ----- design/psss_if.sv -----
// channel interfaces: packet bytes, search results, register writes
interface psss_in_if;
	logic                           valid;
	logic                           ready;
	logic [psss_pkg::BYTE_W-1:0]    data_byte;
	logic                           last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface psss_out_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [psss_pkg::START_W-1:0]   match_start;
	logic [psss_pkg::COUNT_W-1:0]   matched_packets;
	logic                           too_long;

	modport source (output valid, found, match_start, matched_packets, too_long, input ready);
	modport sink   (input valid, found, match_start, matched_packets, too_long, output ready);
endinterface

interface psss_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [psss_pkg::REG_IDX_W-1:0]    index;
	logic [psss_pkg::CFG_DATA_W-1:0]   wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- design/psss_front.sv -----
// front part: pattern registers, byte window and per-byte window compare
module psss_front #(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int MAX_PACKET_BYTES  = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	psss_in_if.sink             pkt_in,
	psss_cfg_if.sink            cfg,
	output logic                push,
	output psss_pkg::item_t     push_item,
	input  logic                push_ready
);

	localparam int WIN_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
	localparam int OFS_W     = $clog2(MAX_PACKET_BYTES + 1);
	localparam int LEN_W     = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	logic [psss_pkg::CFG_DATA_W-1:0] pat_first_q;
	logic [psss_pkg::CFG_DATA_W-1:0] pat_last_q;
	logic [psss_pkg::LEN_CFG_W-1:0]  pat_len_q;

	logic [psss_pkg::BYTE_W-1:0]     win_q [WIN_DEPTH];
	logic [OFS_W-1:0]                offset_q;

	logic [2*psss_pkg::CFG_DATA_W-1:0] pat_all;
	logic [LEN_W-1:0]                eff_len;
	logic [psss_pkg::BYTE_W-1:0]     stream [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0]    byte_ok;
	logic                            over;
	logic                            enough;
	logic                            accept;
	logic [OFS_W:0]                  end_pos;

	assign cfg.ready    = 1'b1;
	assign pkt_in.ready = push_ready;
	assign accept       = pkt_in.valid && push_ready;
	assign pat_all      = {pat_last_q, pat_first_q};

	// zero length acts as one, lengths above the window saturate
	always_comb begin
		if (pat_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (pat_len_q > psss_pkg::LEN_CFG_W'(MAX_PATTERN_BYTES)) begin
			eff_len = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			eff_len = LEN_W'(pat_len_q);
		end
	end

	// stream[0] is the incoming byte, stream[d] the byte d places back
	always_comb begin
		stream[0] = pkt_in.data_byte;
		for (int d = 1; d < MAX_PATTERN_BYTES; d++) begin
			stream[d] = win_q[d-1];
		end
	end

	// pattern byte i lines up with the byte eff_len-1-i places back
	always_comb begin
		logic [LEN_W-1:0] lag;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			lag = LEN_W'(eff_len - LEN_W'(i + 1));
			if (LEN_W'(i) < eff_len) begin
				byte_ok[i] = (pat_all[8*i +: 8] == stream[lag[IDX_W-1:0]]);
			end else begin
				byte_ok[i] = 1'b1;
			end
		end
	end

	assign over    = (offset_q >= OFS_W'(MAX_PACKET_BYTES));
	assign end_pos = (OFS_W+1)'(offset_q) + (OFS_W+1)'(1);
	assign enough  = (end_pos >= (OFS_W+1)'(eff_len));

	assign push                = accept;
	assign push_item.hit       = !over && enough && (&byte_ok);
	assign push_item.start     = psss_pkg::START_W'(end_pos - (OFS_W+1)'(eff_len));
	assign push_item.last      = pkt_in.last_byte;
	assign push_item.over      = over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_first_q <= '0;
			pat_last_q  <= '0;
			pat_len_q   <= psss_pkg::LEN_CFG_W'(1);
		end else if (cfg.valid) begin
			case (psss_pkg::reg_idx_t'(cfg.index))
				psss_pkg::REG_PATTERN_FIRST:  pat_first_q <= cfg.wdata;
				psss_pkg::REG_PATTERN_LAST:   pat_last_q  <= cfg.wdata;
				psss_pkg::REG_PATTERN_LENGTH:
					pat_len_q <= cfg.wdata[psss_pkg::LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			for (int k = 0; k < WIN_DEPTH; k++) begin
				win_q[k] <= '0;
			end
		end else if (accept) begin
			if (pkt_in.last_byte) begin
				offset_q <= '0;
				for (int k = 0; k < WIN_DEPTH; k++) begin
					win_q[k] <= '0;
				end
			end else if (!over) begin
				offset_q <= OFS_W'(offset_q + OFS_W'(1));
				win_q[0] <= pkt_in.data_byte;
				for (int k = 1; k < WIN_DEPTH; k++) begin
					win_q[k] <= win_q[k-1];
				end
			end
		end
	end

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= OFS_W'(MAX_PACKET_BYTES))
		else $error("byte offset ran past the searchable length");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pkt_in.last_byte |=> offset_q == '0)
		else $error("offset not cleared after packet end");

endmodule

// ----- design/psss_fifo.sv -----
// short queue of classified bytes between front and back
module psss_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  psss_pkg::item_t     push_item,
	output logic                push_ready,
	output logic                pop_valid,
	output psss_pkg::item_t     pop_item,
	input  logic                pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	psss_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + PTR_W'(1));
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + PTR_W'(1));
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= CNT_W'(count_q + CNT_W'(1));
				2'b01:   count_q <= CNT_W'(count_q - CNT_W'(1));
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill above its depth");

endmodule

// ----- design/psss_back.sv -----
// back part: first-match tracking, packet count and result register
module psss_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  psss_pkg::item_t     item,
	output logic                item_pop,
	psss_out_if.source          res
);

	logic                           seen_q;
	logic [psss_pkg::START_W-1:0]   first_q;
	logic [psss_pkg::COUNT_W-1:0]   count_q;
	logic                           res_valid_q;
	logic                           found_q;
	logic [psss_pkg::START_W-1:0]   start_q;
	logic                           too_long_q;

	logic                           item_ready;
	logic                           pop_last;
	logic                           found_now;
	logic [psss_pkg::START_W-1:0]   start_now;

	// only a packet end needs the result slot
	assign item_ready = !item.last || !res_valid_q || res.ready;
	assign item_pop   = item_valid && item_ready;
	assign pop_last   = item_pop && item.last;
	assign found_now  = seen_q || item.hit;
	assign start_now  = seen_q ? first_q : item.start;

	assign res.valid           = res_valid_q;
	assign res.found           = found_q;
	assign res.match_start     = start_q;
	assign res.matched_packets = count_q;
	assign res.too_long        = too_long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			first_q     <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop_last) begin
				res_valid_q <= 1'b1;
				seen_q      <= 1'b0;
				first_q     <= '0;
				if (found_now && (count_q != '1)) begin
					count_q <= psss_pkg::COUNT_W'(count_q + psss_pkg::COUNT_W'(1));
				end
			end else if (item_pop && item.hit && !seen_q) begin
				seen_q  <= 1'b1;
				first_q <= item.start;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_last) begin
			found_q    <= found_now;
			start_q    <= found_now ? start_now : '0;
			too_long_q <= item.over;
		end
	end

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop_last |=> res_valid_q)
		else $error("packet end produced no result");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '1 |=> count_q == '1)
		else $error("match count wrapped");

	a_count_held_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |=> $stable(count_q))
		else $error("count changed under a stalled result");

endmodule

// ----- design/packet_substring_search_core.sv -----
// top level of the packet substring search core
//
// usage
//   pkt_in  : one packet byte per request, last_byte marks the final byte
//   res_out : one request per packet, issued for its last byte: found flag,
//             start offset of the first match, saturating count of matching
//             packets since reset, and too_long when the packet ran past the
//             searchable length (later bytes are not searched)
//   cfg     : register writes, index 0 pattern bytes 0-7, 1 bytes 8-15,
//             2 pattern length; always ready, write only while idle
// timing
//   one byte per cycle while the queue has room; the window compare runs in the
//   cycle a byte is taken, the last byte's item passes through the queue and then
//   sets the result register once the back is not held by a waiting result
// reset
//   pattern all zero, length one, empty window, match count zero
// backpressure
//   a stalled result holds; the front keeps taking bytes until the small
//   queue fills, non-final bytes drain even while a result waits
module packet_substring_search_core #(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int MAX_PACKET_BYTES  = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	psss_in_if.sink     pkt_in,
	psss_out_if.source  res_out,
	psss_cfg_if.sink    cfg
);

	// front to queue
	logic            push;
	logic            push_ready;
	psss_pkg::item_t push_item;

	// queue to back
	logic            pop_valid;
	logic            pop;
	psss_pkg::item_t pop_item;

	// front: registers, window shift and compare, classification of each byte
	psss_front #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.MAX_PACKET_BYTES  (MAX_PACKET_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_in     (pkt_in),
		.cfg        (cfg),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	// two entries keep one byte per cycle flowing while the back pops, with a registered fill count
	psss_fifo #(
		.DEPTH (2)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	// back: keeps the first match per packet and issues the result request
	psss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item       (pop_item),
		.item_pop   (pop),
		.res        (res_out)
	);

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the packet substring search core
`timescale 1ns / 1ps

module tb_top;
	import psss_pkg::*;

	// block sizes, kept at the core's defaults
	localparam int MAX_PATTERN_BYTES = 16;
	localparam int MAX_PACKET_BYTES  = 128;
	localparam int WINDOW_DEPTH      = MAX_PATTERN_BYTES - 1;

	// run shape
	localparam int RANDOM_BYTES  = 1250;
	localparam int MAX_WAIT      = 17;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int REPORT_LIMIT  = 10;

	// index with no register behind it, writes to it must change nothing
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [COUNT_W-1:0]   COUNT_MAX  = '1;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} byte_req_t;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] start;
		logic [COUNT_W-1:0] count;
		logic               too_long;
	} search_result_t;

	logic clk;
	logic arst_n;

	psss_in_if  pkt_if ();
	psss_out_if res_if ();
	psss_cfg_if cfg_if ();

	packet_substring_search_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt_in  (pkt_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	// -------------------------------------------------------------------
	// search model: its own copy of the registers and per-packet state
	// -------------------------------------------------------------------
	logic [CFG_DATA_W-1:0] pat_first;
	logic [CFG_DATA_W-1:0] pat_last;
	logic [LEN_CFG_W-1:0]  pat_len_reg;
	logic [BYTE_W-1:0]     recent_bytes [WINDOW_DEPTH];   // entry 0 newest
	int                    pkt_offset;                    // stops at the searchable limit
	logic                  hit_seen;
	logic [START_W-1:0]    hit_start;
	logic [COUNT_W-1:0]    hit_packets;                   // survives packet ends

	byte_req_t      pending_bytes [$];      // requests not yet handed to the core
	search_result_t expected_results [$];   // one per packet still in flight

	bit no_idle;          // when set neither side inserts wait cycles
	int send_wait;
	int recv_wait;
	int mismatches   = 0;
	int results_seen = 0;
	int random_bytes = 0;
	int cycle_count  = 0;

	function automatic logic [BYTE_W-1:0] pattern_byte(input int i);
		if (i < 8)
			return pat_first[8*i +: 8];
		return pat_last[8*(i-8) +: 8];
	endfunction

	// zero means one, anything past the window size is cut to the window size
	function automatic int active_length();
		int len;
		len = pat_len_reg;
		if (len == 0)
			len = 1;
		if (len > MAX_PATTERN_BYTES)
			len = MAX_PATTERN_BYTES;
		return len;
	endfunction

	function automatic void clear_packet();
		int k;
		for (k = 0; k < WINDOW_DEPTH; k++)
			recent_bytes[k] = '0;
		pkt_offset = 0;
		hit_seen   = 1'b0;
		hit_start  = '0;
	endfunction

	// one accepted byte: compare the window ending here, shift, and on the
	// final byte queue the packet's result
	function automatic void predict_search(input logic [BYTE_W-1:0] b, input logic last);
		search_result_t res;
		logic           over;
		logic           hit;
		int             len;
		int             i;
		int             k;
		over = (pkt_offset >= MAX_PACKET_BYTES);
		if (!over) begin
			len = active_length();
			// only a match that starts inside this packet counts
			if (!hit_seen && pkt_offset + 1 >= len) begin
				hit = (pattern_byte(len - 1) == b);
				for (i = 0; i + 1 < len; i++)
					if (pattern_byte(i) != recent_bytes[len - 2 - i])
						hit = 1'b0;
				if (hit) begin
					hit_seen  = 1'b1;
					hit_start = START_W'(pkt_offset + 1 - len);
				end
			end
			for (k = WINDOW_DEPTH - 1; k > 0; k--)
				recent_bytes[k] = recent_bytes[k - 1];
			recent_bytes[0] = b;
			pkt_offset++;
		end
		if (last) begin
			if (hit_seen && hit_packets != COUNT_MAX)
				hit_packets++;
			res.found    = hit_seen;
			res.start    = hit_seen ? hit_start : '0;
			res.count    = hit_packets;
			res.too_long = over;
			expected_results.push_back(res);
			clear_packet();
		end
	endfunction

	function automatic int draw_wait();
		if (no_idle || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// -------------------------------------------------------------------
	// clock
	// -------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// -------------------------------------------------------------------
	// byte driver: pops pending requests, random gap after each one
	// -------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		byte_req_t req;
		if (!arst_n) begin
			pkt_if.valid     <= 1'b0;
			pkt_if.data_byte <= '0;
			pkt_if.last_byte <= 1'b0;
			send_wait        <= 0;
		end else begin
			// the model sees every byte at the edge the core takes it
			if (pkt_if.valid && pkt_if.ready)
				predict_search(pkt_if.data_byte, pkt_if.last_byte);
			if (pkt_if.valid && !pkt_if.ready) begin
				// request still waiting, hold everything
			end else if (send_wait != 0) begin
				pkt_if.valid <= 1'b0;
				send_wait    <= send_wait - 1;
			end else if (pending_bytes.size() != 0) begin
				req = pending_bytes.pop_front();
				pkt_if.valid     <= 1'b1;
				pkt_if.data_byte <= req.data;
				pkt_if.last_byte <= req.last;
				send_wait        <= draw_wait();
			end else begin
				pkt_if.valid <= 1'b0;
			end
		end
	end

	// -------------------------------------------------------------------
	// result monitor: random stalls on ready, in-order field compare
	// -------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		search_result_t got;
		search_result_t want;
		int             w;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			recv_wait    <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got.found    = res_if.found;
				got.start    = res_if.match_start;
				got.count    = res_if.matched_packets;
				got.too_long = res_if.too_long;
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"result %0d with nothing expected: ",
							"found %0b start %0d count %0d too_long %0b"},
							results_seen, got.found, got.start, got.count,
							got.too_long);
				end else begin
					want = expected_results.pop_front();
					if (got.found !== want.found || got.start !== want.start ||
						got.count !== want.count || got.too_long !== want.too_long) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"result %0d: expected found %0b start %0d ",
								"count %0d too_long %0b, got found %0b start %0d ",
								"count %0d too_long %0b"},
								results_seen, want.found, want.start, want.count,
								want.too_long, got.found, got.start, got.count,
								got.too_long);
					end
				end
				w = draw_wait();
				recv_wait    <= w;
				res_if.ready <= (w == 0);
			end else if (recv_wait != 0) begin
				recv_wait    <= recv_wait - 1;
				res_if.ready <= (recv_wait == 1);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// -------------------------------------------------------------------
	// watchdog
	// -------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// -------------------------------------------------------------------
	// stimulus helpers
	// -------------------------------------------------------------------

	// register write request, model copy updated once the core takes it
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.wdata <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_PATTERN_FIRST:  pat_first   = value;
			REG_PATTERN_LAST:   pat_last    = value;
			REG_PATTERN_LENGTH: pat_len_reg = value[LEN_CFG_W-1:0];
			default: ;
		endcase
	endtask

	// all bytes sent, all results back, then a short settle for the pipeline;
	// sampled between edges so the driver's updates of the same edge are seen
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || pkt_if.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// packet of lead_n copies of lead followed by fill_n copies of fill
	task automatic queue_run(input logic [BYTE_W-1:0] lead, input int lead_n,
		input logic [BYTE_W-1:0] fill, input int fill_n);
		int k;
		for (k = 0; k < lead_n + fill_n; k++)
			pending_bytes.push_back(byte_req_t'({(k < lead_n) ? lead : fill,
				k == lead_n + fill_n - 1}));
	endtask

	// random packet, mostly short, with the pattern planted in various ways
	task automatic gen_packet(input logic [BYTE_W-1:0] alphabet [$]);
		logic [BYTE_W-1:0] bytes [$];
		int n;
		int plen;
		int at;
		int skip;
		int k;
		plen = active_length();
		case ($urandom_range(0, 19))
			0:       n = $urandom_range(MAX_PACKET_BYTES + 1, MAX_PACKET_BYTES + 24);
			1, 2, 3: n = $urandom_range(41, MAX_PACKET_BYTES);
			default: n = $urandom_range(1, 40);
		endcase
		for (k = 0; k < n; k++)
			if (alphabet.size() == 0)
				bytes.push_back(BYTE_W'($urandom));
			else
				bytes.push_back(alphabet[$urandom_range(0, alphabet.size() - 1)]);
		if (n > MAX_PACKET_BYTES && $urandom_range(0, 1) == 1) begin
			// around the end of the searched part: last legal spot, straddling it or past it
			at = $urandom_range(MAX_PACKET_BYTES - plen, n - plen);
			for (k = 0; k < plen; k++)
				bytes[at + k] = pattern_byte(k);
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					if (n >= plen) begin
						at = $urandom_range(0, n - plen);
						for (k = 0; k < plen; k++)
							bytes[at + k] = pattern_byte(k);
					end
				end
				4: begin
					// two copies, the first one in the packet must win
					if (n >= plen)
						repeat (2) begin
							at = $urandom_range(0, n - plen);
							for (k = 0; k < plen; k++)
								bytes[at + k] = pattern_byte(k);
						end
				end
				5: begin
					// pattern cut short by the packet end
					at = (n >= plen) ? n - plen + 1 : 0;
					for (k = 0; at + k < n; k++)
						bytes[at + k] = pattern_byte(k);
				end
				6: begin
					// packet opens with the pattern's tail, so a prefix left in the
					// previous packet must not complete it
					if (plen > 1) begin
						skip = $urandom_range(1, plen - 1);
						for (k = 0; k < plen - skip && k < n; k++)
							bytes[k] = pattern_byte(skip + k);
					end
				end
				default: ;
			endcase
		end
		for (k = 0; k < n; k++)
			pending_bytes.push_back(byte_req_t'({bytes[k], k == n - 1}));
		random_bytes += n;
	endtask

	// -------------------------------------------------------------------
	// main sequence
	// -------------------------------------------------------------------
	initial begin
		logic [BYTE_W-1:0]     alphabet [$];
		logic [CFG_DATA_W-1:0] words [2];
		logic [CFG_DATA_W-1:0] len_word;
		logic [LEN_CFG_W-1:0]  len_code;
		int                    phase;
		int                    n;
		int                    j;
		int                    k;

		// every input known from time zero, reset held low
		arst_n           = 1'b0;
		pkt_if.valid     = 1'b0;
		pkt_if.data_byte = '0;
		pkt_if.last_byte = 1'b0;
		res_if.ready     = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = REG_PATTERN_FIRST;
		cfg_if.wdata     = '0;
		no_idle          = 1'b0;

		// model at its reset values
		pat_first   = '0;
		pat_last    = '0;
		pat_len_reg = LEN_CFG_W'(1);
		hit_packets = '0;
		clear_packet();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset pattern: one zero byte
		queue_run(8'h00, 0, 8'h00, 1);          // match at offset zero
		queue_run(8'hFF, 1, 8'h00, 1);          // match at offset one
		queue_run(8'hFF, 1, 8'h00, 0);          // no match
		wait_idle();

		// four zero bytes; the window starts out zero, so too short a packet
		// must not match; the unused index must leave the length alone
		write_reg(REG_PATTERN_FIRST, '0);
		write_reg(REG_PATTERN_LAST, '1);
		write_reg(REG_PATTERN_LENGTH, 64'd4);
		write_reg(REG_UNUSED, 64'h1);
		queue_run(8'h00, 0, 8'h00, 3);          // shorter than the pattern
		queue_run(8'h00, 0, 8'h00, 4);          // exactly the pattern
		queue_run(8'hFF, 1, 8'h00, 5);          // first match at offset one
		wait_idle();

		// random phases, each with its own pattern and length
		phase = 0;
		while (random_bytes < RANDOM_BYTES) begin
			// half the phases draw bytes from a tiny alphabet for near misses
			alphabet.delete();
			if ($urandom_range(0, 1) == 1) begin
				n = $urandom_range(2, 4);
				for (k = 0; k < n; k++)
					alphabet.push_back(BYTE_W'($urandom));
			end
			for (k = 0; k < 2; k++) begin
				words[k] = {$urandom, $urandom};
				if (alphabet.size() != 0)
					for (j = 0; j < 8; j++)
						words[k][8*j +: 8] = alphabet[$urandom_range(0, alphabet.size() - 1)];
			end
			// length codes cycle through the extremes and the clamped values
			case (phase % 7)
				0:       len_code = LEN_CFG_W'(1);
				1:       len_code = LEN_CFG_W'(MAX_PATTERN_BYTES);
				2:       len_code = '0;
				3:       len_code = '1;
				4:       len_code = LEN_CFG_W'(MAX_PATTERN_BYTES + 1);
				default: len_code = LEN_CFG_W'($urandom_range(2, MAX_PATTERN_BYTES - 1));
			endcase
			len_word = {$urandom, $urandom};
			len_word[LEN_CFG_W-1:0] = len_code;
			no_idle = ($urandom_range(0, 3) == 0);

			write_reg(REG_PATTERN_FIRST, words[0]);
			write_reg(REG_PATTERN_LAST, words[1]);
			write_reg(REG_PATTERN_LENGTH, len_word);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, {$urandom, $urandom});

			n = $urandom_range(3, 8);
			for (k = 0; k < n; k++)
				gen_packet(alphabet);
			wait_idle();
			phase++;
		end

		no_idle = 1'b0;
		for (k = 0; k < 6; k++)
			gen_packet(alphabet);
		wait_idle();

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/psss_pkg.sv
design/psss_if.sv
design/psss_front.sv
design/psss_fifo.sv
design/psss_back.sv
design/packet_substring_search_core.sv
tb/tb_top.sv
